// File: rtl/fvd_pkg.sv
// Shared types and constants for the feature vector distance core.
`default_nettype none

package fvd_pkg;

    // Width of the accumulated distance and of its saturation value.
    localparam int DIST_W = 60;
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // Result beat data width, the distance padded to whole bytes.
    localparam int M_DATA_W = ((DIST_W + 7) / 8) * 8;

    // Register file layout: one word-aligned register.
    localparam int CFG_ADDR_W = 3;
    localparam logic REG_DISTANCE_MODE = 1'b0;

    // Depth of the queue between the front end and the execution unit.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Distance kinds selected by the mode register.
    typedef enum logic [1:0] {
        MODE_L1  = 2'd0,
        MODE_L2  = 2'd1,
        MODE_CHI = 2'd2,
        MODE_BAD = 2'd3
    } mode_t;

    // Execution unit states.
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_DIV,
        BK_ACC
    } back_state_t;

    // Queue status flags, full and empty, seen by the top level.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

`default_nettype wire

// File: rtl/fvd_front.sv
// Front end: accepts element pairs, forms |a-b| and a+b+1, tags them with the mode.
`default_nettype none

module fvd_front #(
    parameter int SAMPLE_BITS = 16,
    parameter int S_DATA_W    = 32,
    parameter int ENTRY_W     = 2 * SAMPLE_BITS + 4
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,
    input  wire logic                s_tlast,
    input  wire fvd_pkg::mode_t      mode,
    output logic                     push_valid,
    input  wire logic                push_ready,
    output logic [ENTRY_W-1:0]       push_data
);
    import fvd_pkg::*;

    typedef struct packed {
        mode_t                  mode;
        logic                   last;
        logic [SAMPLE_BITS-1:0] diff;
        logic [SAMPLE_BITS:0]   dsum;
    } entry_t;

    logic [SAMPLE_BITS-1:0] elem_a;
    logic [SAMPLE_BITS-1:0] elem_b;
    entry_t                 entry_next;
    entry_t                 entry_reg;
    logic                   valid_reg;
    logic                   valid_next;

    // Split the beat into the two samples.
    assign elem_a = s_tdata[SAMPLE_BITS-1:0];
    assign elem_b = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

    // Classify the pair: absolute difference, chi-square divisor and mode.
    always_comb begin
        entry_next.mode = mode;
        entry_next.last = s_tlast;
        entry_next.diff = (elem_a >= elem_b) ? (elem_a - elem_b) : (elem_b - elem_a);
        entry_next.dsum = {1'b0, elem_a} + {1'b0, elem_b} + {{SAMPLE_BITS{1'b0}}, 1'b1};
    end

    // The stage takes a new beat whenever its register is empty or drains.
    assign s_tready   = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_data  = entry_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (push_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            entry_reg <= entry_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/fvd_queue.sv
// Short queue that decouples the front end from the execution unit.
`default_nettype none

module fvd_queue #(
    parameter int WIDTH = 36
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push_valid,
    output logic                   push_ready,
    input  wire logic [WIDTH-1:0]  push_data,
    output logic                   pop_valid,
    input  wire logic              pop_ready,
    output logic [WIDTH-1:0]       pop_data,
    output fvd_pkg::queue_status_t status
);
    import fvd_pkg::*;

    logic [WIDTH-1:0]       slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic                   do_push;
    logic                   do_pop;

    assign status.full  = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign push_ready   = !status.full;
    assign pop_valid    = !status.empty;
    assign pop_data     = slot_reg[rd_ptr_reg];
    assign do_push      = push_valid && push_ready;
    assign do_pop       = pop_valid && pop_ready;

    // Pointers wrap naturally since the depth is a power of two.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/fvd_back.sv
// Execution unit: term arithmetic, serial divider, saturating accumulator, result register.
`default_nettype none

module fvd_back #(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 8,
    parameter int ENTRY_W     = 2 * SAMPLE_BITS + 4
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         pop_valid,
    output logic                              pop_ready,
    input  wire logic [ENTRY_W-1:0]           pop_data,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [fvd_pkg::M_DATA_W-1:0]      m_tdata,
    output logic [0:0]                        m_tuser
);
    import fvd_pkg::*;

    localparam int NUM_W  = 2 * SAMPLE_BITS + FRAC_BITS;
    localparam int WIDE_W = (NUM_W > DIST_W) ? NUM_W : DIST_W;
    localparam int CNT_W  = $clog2(NUM_W + 1);

    typedef struct packed {
        mode_t                  mode;
        logic                   last;
        logic [SAMPLE_BITS-1:0] diff;
        logic [SAMPLE_BITS:0]   dsum;
    } entry_t;

    entry_t                     entry;
    back_state_t                state_reg, state_next;
    mode_t                      mode_reg, mode_next;
    logic                       last_reg, last_next;
    logic [SAMPLE_BITS-1:0]     diff_reg, diff_next;
    logic [SAMPLE_BITS:0]       dsum_reg, dsum_next;
    logic [NUM_W-1:0]           num_reg, num_next;
    logic [SAMPLE_BITS:0]       rem_reg, rem_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [DIST_W-1:0]          term_reg, term_next;
    logic [DIST_W-1:0]          acc_reg, acc_next;
    logic                       out_valid_reg, out_valid_next;
    logic [DIST_W-1:0]          dist_reg, dist_next;
    logic                       err_reg, err_next;
    logic [2*SAMPLE_BITS-1:0]   square;
    logic [NUM_W-1:0]           square_scaled;
    logic [SAMPLE_BITS+1:0]     rem_shift;
    logic                       qbit;
    logic [NUM_W-1:0]           num_shift;
    logic [DIST_W:0]            acc_sum;
    logic [DIST_W-1:0]          acc_sat;

    // Clamp a wide term to the largest distance.
    function automatic logic [DIST_W-1:0] sat_term(input logic [WIDE_W-1:0] v);
        logic [DIST_W-1:0] r;
        if (v > WIDE_W'(DIST_MAX)) begin
            r = DIST_MAX;
        end else begin
            r = v[DIST_W-1:0];
        end
        return r;
    endfunction

    assign entry = entry_t'(pop_data);

    // Combinational datapath pieces for the square, the divider and the accumulator.
    assign square        = diff_reg * diff_reg;
    assign square_scaled = NUM_W'(square) << FRAC_BITS;
    assign rem_shift     = {rem_reg, num_reg[NUM_W-1]};
    assign qbit          = (rem_shift >= {1'b0, dsum_reg});
    assign num_shift     = {num_reg[NUM_W-2:0], qbit};
    assign acc_sum       = {1'b0, acc_reg} + {1'b0, term_reg};
    assign acc_sat       = acc_sum[DIST_W] ? DIST_MAX : acc_sum[DIST_W-1:0];

    // Sequencer: load, square, divide one quotient bit a cycle, accumulate.
    always_comb begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        last_next      = last_reg;
        diff_next      = diff_reg;
        dsum_next      = dsum_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        term_next      = term_reg;
        acc_next       = acc_reg;
        dist_next      = dist_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg && !m_tready;
        pop_ready      = 1'b0;

        case (state_reg)
            BK_IDLE: begin
                pop_ready = 1'b1;
                if (pop_valid) begin
                    mode_next = entry.mode;
                    last_next = entry.last;
                    diff_next = entry.diff;
                    dsum_next = entry.dsum;
                    case (entry.mode)
                        MODE_L1: begin
                            term_next  = sat_term(WIDE_W'(entry.diff) << FRAC_BITS);
                            state_next = BK_ACC;
                        end
                        MODE_L2, MODE_CHI: begin
                            state_next = BK_MUL;
                        end
                        default: begin
                            term_next  = '0;
                            state_next = BK_ACC;
                        end
                    endcase
                end
            end
            BK_MUL: begin
                if (mode_reg == MODE_L2) begin
                    term_next  = sat_term(WIDE_W'(square_scaled));
                    state_next = BK_ACC;
                end else begin
                    num_next   = square_scaled;
                    rem_next   = '0;
                    cnt_next   = CNT_W'(NUM_W);
                    state_next = BK_DIV;
                end
            end
            BK_DIV: begin
                if (qbit) begin
                    rem_next = (SAMPLE_BITS+1)'(rem_shift - {1'b0, dsum_reg});
                end else begin
                    rem_next = rem_shift[SAMPLE_BITS:0];
                end
                num_next = num_shift;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    term_next  = sat_term(WIDE_W'(num_shift));
                    state_next = BK_ACC;
                end
            end
            BK_ACC: begin
                if (!last_reg) begin
                    acc_next   = acc_sat;
                    state_next = BK_IDLE;
                end else if (!out_valid_reg || m_tready) begin
                    // Final element: form the result and clear the sum.
                    out_valid_next = 1'b1;
                    if (mode_reg == MODE_BAD) begin
                        dist_next = '0;
                        err_next  = 1'b1;
                    end else if (mode_reg == MODE_CHI && acc_sat != DIST_MAX) begin
                        dist_next = acc_sat >> 1;
                        err_next  = 1'b0;
                    end else begin
                        dist_next = acc_sat;
                        err_next  = 1'b0;
                    end
                    acc_next   = '0;
                    state_next = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg <= mode_next;
        last_reg <= last_next;
        diff_reg <= diff_next;
        dsum_reg <= dsum_next;
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
        term_reg <= term_next;
        dist_reg <= dist_next;
        err_reg  <= err_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'(dist_reg);
    assign m_tuser  = err_reg;

endmodule

`default_nettype wire

// File: rtl/feature_vector_distance_core.sv
// Feature vector distance core: L1, squared L2 or chi-square over a stream of element pairs.
//
// Input channel (s_): one beat per element pair, elem_a in the low SAMPLE_BITS of s_tdata,
// elem_b above it, s_tlast on the final pair of a vector. Result channel (m_): one beat per
// vector, the distance with FRAC_BITS fraction bits in m_tdata, mode_error in m_tuser.
// The mode register sits at APB byte address 0 and must be written only while the core is idle;
// the core itself does not enforce this. A front register stage and a four-entry queue take
// beats while the execution unit works. The sequencer in fvd_back loads each pair, squares
// it in squared L2 and chi-square mode and adds the term to the sum; in chi-square the square
// first goes through the one-bit-per-cycle restoring divider, which makes chi-square pairs the
// slowest. The last pair of a vector passes the front register, the queue and the sequencer
// before m_tvalid rises from the output register.
// The result waits in an output register while m_tready is low; the queue keeps filling
// and s_tready drops once the front stage and queue are full.
// Synchronous reset clears the mode to L1, the sum, the queue and the output register.
`default_nettype none

module feature_vector_distance_core #(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 8
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // s_tdata fields from bit 0 up: elem_a, elem_b
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    input  wire logic                               s_tlast,
    // m_tdata fields from bit 0 up: distance
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [fvd_pkg::M_DATA_W-1:0]            m_tdata,
    // m_tuser fields from bit 0 up: mode_error
    output logic [0:0]                              m_tuser,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [fvd_pkg::CFG_ADDR_W-1:0]     paddr,
    input  wire logic [31:0]                        pwdata,
    output logic [31:0]                             prdata,
    output logic                                    pready
);
    import fvd_pkg::*;

    localparam int S_DATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int ENTRY_W  = 2 * SAMPLE_BITS + 4;

    mode_t              mode_reg;
    logic               cfg_write;
    logic               push_valid;
    logic               push_ready;
    logic [ENTRY_W-1:0] push_data;
    logic               pop_valid;
    logic               pop_ready;
    logic [ENTRY_W-1:0] pop_data;
    queue_status_t      q_status;

    // Configuration register.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_L1;
        end else if (cfg_write && paddr[2] == REG_DISTANCE_MODE) begin
            mode_reg <= mode_t'(pwdata[1:0]);
        end
    end

    assign prdata = (paddr[2] == REG_DISTANCE_MODE) ? {30'd0, mode_reg} : 32'd0;

    fvd_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .S_DATA_W    (S_DATA_W),
        .ENTRY_W     (ENTRY_W)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .mode       (mode_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    fvd_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data),
        .status     (q_status)
    );

    fvd_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS),
        .ENTRY_W     (ENTRY_W)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // An error result never carries a distance.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("error result carries a nonzero distance");

    // The queue is never reported full and empty at once.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_status.full && q_status.empty))
        else $error("queue status is inconsistent");

    // Reset leaves no result pending.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A full queue holds back the front stage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_status.full && !pop_ready) |-> !push_ready)
        else $error("queue accepted an entry while full");

endmodule

`default_nettype wire

// File: tb/sv/feature_vector_distance_core_test.sv
// Self-checking testbench for the feature vector distance core with a built-in distance predictor.
`timescale 1ns / 100ps

module feature_vector_distance_core_test;
    import fvd_pkg::*;

    localparam int SAMPLE_W = 16;
    localparam int FRAC_W   = 8;

    // Byte addresses of the mode register and of the first unused register slot.
    localparam logic [CFG_ADDR_W-1:0] MODE_ADDR  = CFG_ADDR_W'(4 * REG_DISTANCE_MODE);
    localparam logic [CFG_ADDR_W-1:0] SPARE_ADDR = CFG_ADDR_W'(MODE_ADDR + 4);

    // Slowest pair is chi-square; the front stage, queue and execution unit can hold a few.
    localparam int CHI_PAIR_CYCLES = 2 * SAMPLE_W + FRAC_W + 3;
    localparam int SETTLE_CYCLES   = (QUEUE_DEPTH + 3) * CHI_PAIR_CYCLES + 16;
    localparam int WATCHDOG_LIMIT  = 8 * SETTLE_CYCLES;
    localparam int DIRECTED_PAIRS  = 23;
    localparam int RANDOM_PAIRS    = 650;

    typedef enum logic [2:0] {
        OP_PAIR,
        OP_WRITE,
        OP_READ,
        OP_DRAIN,
        OP_SETTLE
    } op_kind_t;

    typedef enum logic [2:0] {
        DRV_NEXT,
        DRV_GAP,
        DRV_BEAT,
        DRV_SETUP,
        DRV_ACCESS,
        DRV_DRAIN
    } drv_state_t;

    // One queued stimulus step; gap is the idle time before it, or the hold length of a settle.
    typedef struct {
        op_kind_t                 kind;
        logic [SAMPLE_W-1:0]      a;
        logic [SAMPLE_W-1:0]      b;
        logic                     last;
        logic [CFG_ADDR_W-1:0]    addr;
        logic [31:0]              wdata;
        int unsigned              gap;
    } stim_op_t;

    typedef struct {
        logic [DIST_W-1:0] distance;
        logic              mode_error;
        mode_t             mode;
    } vector_distance_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata  = '0;
    logic                  s_tlast  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [0:0]            m_tuser;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr    = '0;
    logic [31:0]           pwdata   = '0;
    logic [31:0]           prdata;
    logic                  pready;

    stim_op_t         pair_stream[$];
    vector_distance_t due_distances[$];
    stim_op_t         cur_op;
    drv_state_t       drv_state = DRV_NEXT;
    int unsigned      hold_cnt = 0;
    bit               stim_done = 1'b0;

    // Predictor state: the configured mode and the running sum.
    mode_t             cfg_mode = MODE_L1;
    logic [DIST_W-1:0] dist_sum = '0;

    int unsigned pairs_planned = 0;
    int unsigned pairs_taken   = 0;
    int unsigned reg_writes    = 0;
    int unsigned fail_count    = 0;
    int unsigned results_seen[4] = '{0, 0, 0, 0};

    int unsigned rx_hold   = 0;
    int unsigned rx_span   = 0;
    bit          rx_steady = 1'b0;
    int unsigned rx_roll;
    int unsigned idle_cycles = 0;

    feature_vector_distance_core #(
        .SAMPLE_BITS(SAMPLE_W),
        .FRAC_BITS  (FRAC_W)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),     // fields from bit 0 up: elem_a, elem_b
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),     // fields from bit 0 up: distance
        .m_tuser (m_tuser),     // fields from bit 0 up: mode_error
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Clock, 12 ns period.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // One distance term with FRAC_W fraction bits, saturated to the sum width.
    function automatic logic [DIST_W-1:0] pair_term(logic [SAMPLE_W-1:0] a,
                                                    logic [SAMPLE_W-1:0] b, mode_t m);
        logic [63:0] diff;
        logic [63:0] sq;
        logic [63:0] t;
        diff = (a >= b) ? a - b : b - a;
        sq   = diff * diff;
        case (m)
            MODE_L1:  t = diff << FRAC_W;
            MODE_L2:  t = sq << FRAC_W;
            MODE_CHI: t = (sq << FRAC_W) / (64'(a) + 64'(b) + 64'd1);
            default:  t = '0;
        endcase
        return (t > 64'(DIST_MAX)) ? DIST_MAX : t[DIST_W-1:0];
    endfunction

    // Fold one accepted pair into the sum; the last pair of a vector yields its distance.
    task automatic fold_pair(logic [SAMPLE_W-1:0] a, logic [SAMPLE_W-1:0] b, logic last);
        logic [DIST_W:0]  total;
        vector_distance_t due;
        total    = {1'b0, dist_sum} + {1'b0, pair_term(a, b, cfg_mode)};
        dist_sum = total[DIST_W] ? DIST_MAX : total[DIST_W-1:0];
        pairs_taken++;
        if (last) begin
            due.mode = cfg_mode;
            if (cfg_mode == MODE_BAD) begin
                due.distance   = '0;
                due.mode_error = 1'b1;
            end else begin
                due.mode_error = 1'b0;
                due.distance   = (cfg_mode == MODE_CHI && dist_sum != DIST_MAX) ?
                                 dist_sum >> 1 : dist_sum;
            end
            due_distances.push_back(due);
            dist_sum = '0;
        end
    endtask

    // Put the next queued step on the pins.
    task automatic start_op();
        case (cur_op.kind)
            OP_PAIR: begin
                s_tvalid  <= 1'b1;
                s_tdata   <= {cur_op.b, cur_op.a};
                s_tlast   <= cur_op.last;
                drv_state <= DRV_BEAT;
            end
            OP_WRITE, OP_READ: begin
                psel      <= 1'b1;
                penable   <= 1'b0;
                pwrite    <= (cur_op.kind == OP_WRITE);
                paddr     <= cur_op.addr;
                pwdata    <= cur_op.wdata;
                drv_state <= DRV_SETUP;
            end
            OP_DRAIN: drv_state <= DRV_DRAIN;
            default:  drv_state <= DRV_NEXT;
        endcase
    endtask

    // Driver: pair beats on the input channel and register accesses, taken from the queue.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            s_tlast   <= 1'b0;
            s_tdata   <= '0;
            psel      <= 1'b0;
            penable   <= 1'b0;
            pwrite    <= 1'b0;
            paddr     <= '0;
            pwdata    <= '0;
            drv_state <= DRV_NEXT;
        end else begin
            case (drv_state)
                DRV_NEXT: begin
                    if (pair_stream.size() != 0) begin
                        cur_op = pair_stream.pop_front();
                        if (cur_op.gap != 0) begin
                            hold_cnt  <= cur_op.gap;
                            drv_state <= DRV_GAP;
                        end else begin
                            start_op();
                        end
                    end else begin
                        stim_done <= 1'b1;
                    end
                end
                DRV_GAP: begin
                    if (hold_cnt <= 1) begin
                        start_op();
                    end else begin
                        hold_cnt <= hold_cnt - 1;
                    end
                end
                DRV_BEAT: begin
                    if (s_tready) begin
                        fold_pair(s_tdata[SAMPLE_W-1:0], s_tdata[2*SAMPLE_W-1:SAMPLE_W], s_tlast);
                        // Back-to-back beats keep tvalid high.
                        if (pair_stream.size() != 0 && pair_stream[0].kind == OP_PAIR &&
                            pair_stream[0].gap == 0) begin
                            cur_op = pair_stream.pop_front();
                            start_op();
                        end else begin
                            s_tvalid  <= 1'b0;
                            drv_state <= DRV_NEXT;
                        end
                    end
                end
                DRV_SETUP: begin
                    penable   <= 1'b1;
                    drv_state <= DRV_ACCESS;
                end
                DRV_ACCESS: begin
                    if (pready) begin
                        if (pwrite) begin
                            reg_writes++;
                            if (paddr == MODE_ADDR)
                                cfg_mode = mode_t'(pwdata[1:0]);
                        end else if (prdata !== {30'd0, cfg_mode}) begin
                            $display("%0t: mode register read expected %h, got %h",
                                     $time, {30'd0, cfg_mode}, prdata);
                            fail_count++;
                        end
                        psel      <= 1'b0;
                        penable   <= 1'b0;
                        pwrite    <= 1'b0;
                        drv_state <= DRV_NEXT;
                    end
                end
                DRV_DRAIN: begin
                    if (due_distances.size() == 0)
                        drv_state <= DRV_NEXT;
                end
                default: drv_state <= DRV_NEXT;
            endcase
        end
    end

    // Monitor: random backpressure on the result channel and a check of every result beat.
    always @(posedge aclk) begin
        vector_distance_t due;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_hold  <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (due_distances.size() == 0) begin
                    $display("%0t: result with none expected, distance %h, mode_error %b",
                             $time, m_tdata[DIST_W-1:0], m_tuser[0]);
                    fail_count++;
                end else begin
                    due = due_distances.pop_front();
                    results_seen[due.mode]++;
                    if (m_tdata[DIST_W-1:0] !== due.distance) begin
                        $display("%0t: distance expected %h, got %h",
                                 $time, due.distance, m_tdata[DIST_W-1:0]);
                        fail_count++;
                    end
                    if (m_tuser[0] !== due.mode_error) begin
                        $display("%0t: mode_error expected %b, got %b",
                                 $time, due.mode_error, m_tuser[0]);
                        fail_count++;
                    end
                end
            end

            // Alternate stretches of steady acceptance with random stalls.
            if (rx_span == 0) begin
                rx_steady <= ($urandom_range(0, 3) == 0);
                rx_span   <= $urandom_range(20, 200);
            end else begin
                rx_span <= rx_span - 1;
            end

            if (rx_hold != 0) begin
                rx_hold  <= rx_hold - 1;
                m_tready <= (rx_hold == 1);
            end else if (rx_steady) begin
                m_tready <= 1'b1;
            end else begin
                rx_roll = $urandom_range(0, 99);
                if (rx_roll < 70) begin
                    m_tready <= 1'b1;
                end else if (rx_roll < 94) begin
                    m_tready <= 1'b0;
                    rx_hold  <= $urandom_range(1, 3);
                end else begin
                    m_tready <= 1'b0;
                    rx_hold  <= $urandom_range(10, 50);
                end
            end
        end
    end

    // Watchdog on cycles in which no beat and no register access completes.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, idle_cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        else if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Sample styles: 0 full range, 1 small values, 2 near-equal pairs, 3 mostly extremes.
    function automatic logic [SAMPLE_W-1:0] pick_sample(int unsigned style);
        int unsigned roll;
        roll = $urandom_range(0, 2);
        case (style)
            1: return SAMPLE_W'($urandom_range(0, 31));
            3: return (roll == 0) ? '0 : (roll == 1) ? '1 : SAMPLE_W'($urandom_range(0, 65535));
            default: return SAMPLE_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic push_pair(logic [SAMPLE_W-1:0] a, logic [SAMPLE_W-1:0] b, logic last,
                             int unsigned gap);
        stim_op_t op;
        op.kind  = OP_PAIR;
        op.a     = a;
        op.b     = b;
        op.last  = last;
        op.addr  = '0;
        op.wdata = '0;
        op.gap   = gap;
        pair_stream.push_back(op);
        pairs_planned++;
    endtask

    task automatic push_access(op_kind_t kind, logic [CFG_ADDR_W-1:0] addr, logic [31:0] data,
                               int unsigned gap);
        stim_op_t op;
        op.kind  = kind;
        op.a     = '0;
        op.b     = '0;
        op.last  = 1'b0;
        op.addr  = addr;
        op.wdata = data;
        op.gap   = gap;
        pair_stream.push_back(op);
    endtask

    // Wait for all owed distances, then for any pairs still in the core to finish.
    task automatic push_quiesce();
        push_access(OP_DRAIN, '0, '0, 0);
        push_access(OP_SETTLE, '0, '0, SETTLE_CYCLES);
    endtask

    // Mode write with junk in the unused upper bits, then a read back.
    task automatic set_mode(mode_t m);
        push_quiesce();
        push_access(OP_WRITE, MODE_ADDR, ($urandom() & ~32'h3) | 32'(m), 0);
        push_access(OP_READ, MODE_ADDR, '0, 0);
    endtask

    task automatic push_random_pair(int unsigned style, bit steady, logic last);
        logic [SAMPLE_W-1:0] a;
        logic [SAMPLE_W-1:0] b;
        a = pick_sample(style);
        if (style == 2)
            b = $urandom_range(0, 1) ? a : a ^ SAMPLE_W'(1 << $urandom_range(0, SAMPLE_W - 1));
        else
            b = pick_sample(style);
        push_pair(a, b, last, steady ? 0 : pick_gap());
    endtask

    initial begin
        int unsigned vec_len;
        int unsigned split;
        int unsigned style;
        int unsigned n_vec;
        int unsigned roll;
        bit          steady;

        // Reset value of the mode, then L1 at the sample extremes.
        push_access(OP_READ, MODE_ADDR, '0, 0);
        push_pair(0, 0, 1'b1, 0);
        push_pair('1, 0, 1'b0, 0);
        push_pair(0, '1, 1'b1, 0);
        push_pair('1, '1, 1'b1, 2);

        // Squared L2, including the largest possible term.
        set_mode(MODE_L2);
        push_pair('1, 0, 1'b1, 0);
        push_pair(1, 0, 1'b0, 0);
        push_pair(0, 1, 1'b1, 0);
        push_pair(12345, 54321, 1'b1, 1);

        // Chi-square: divide by one, truncation and the halving of odd sums.
        set_mode(MODE_CHI);
        push_pair(0, '1, 1'b1, 0);
        push_pair(0, 0, 1'b1, 0);
        push_pair('1, 16'hFFFE, 1'b1, 0);
        push_pair(1, 0, 1'b1, 0);
        push_pair(3, 0, 1'b0, 0);
        push_pair(5, 9, 1'b1, 0);

        // A write outside the register file leaves the mode alone.
        push_quiesce();
        push_access(OP_WRITE, SPARE_ADDR, '1, 0);
        push_access(OP_READ, MODE_ADDR, '0, 0);
        push_pair(100, 7, 1'b1, 0);

        // Unsupported mode flags the result and zeroes the distance.
        set_mode(MODE_BAD);
        push_pair(500, 1, 1'b0, 0);
        push_pair('1, 0, 1'b1, 0);

        // Mode changes in the middle of a vector; the last pair decides halving and error.
        push_pair(10, 0, 1'b0, 0);
        set_mode(MODE_L1);
        push_pair(4, 1, 1'b0, 0);
        set_mode(MODE_CHI);
        push_pair(9, 0, 1'b1, 0);
        push_pair(7, 2, 1'b0, 0);
        set_mode(MODE_BAD);
        push_pair(1, 1, 1'b1, 0);
        set_mode(MODE_L2);
        push_pair(0, 0, 1'b1, 0);

        // Random phases: a mode per phase, then vectors of random length and content.
        while (pairs_planned < DIRECTED_PAIRS + RANDOM_PAIRS) begin
            set_mode(mode_t'($urandom_range(0, 3)));
            if ($urandom_range(0, 5) == 0) begin
                push_access(OP_WRITE, SPARE_ADDR, $urandom(), 0);
                push_access(OP_READ, MODE_ADDR, '0, 0);
            end
            n_vec = $urandom_range(3, 10);
            repeat (n_vec) begin
                roll    = $urandom_range(0, 99);
                vec_len = (roll < 70) ? $urandom_range(1, 6) :
                          (roll < 95) ? $urandom_range(7, 20) : $urandom_range(21, 48);
                split   = (vec_len > 1 && $urandom_range(0, 9) == 0) ?
                          $urandom_range(1, vec_len - 1) : 0;
                style   = $urandom_range(0, 3);
                steady  = ($urandom_range(0, 3) == 0);
                for (int i = 0; i < vec_len; i++) begin
                    if (split != 0 && i == split)
                        set_mode(mode_t'($urandom_range(0, 3)));
                    push_random_pair(style, steady, i == vec_len - 1);
                end
            end
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (!(stim_done && due_distances.size() == 0))
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Run covered %0d pair beats and %0d register writes, checking %0d distances.",
                 pairs_taken, reg_writes,
                 results_seen[0] + results_seen[1] + results_seen[2] + results_seen[3]);
        $display("Distances by mode: L1 %0d, L2 %0d, chi-square %0d, unsupported %0d.",
                 results_seen[0], results_seen[1], results_seen[2], results_seen[3]);
        if (fail_count == 0 && due_distances.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches, %0d distances never arrived",
                     fail_count, due_distances.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: feature_vector_distance_core.f
rtl/fvd_pkg.sv
rtl/fvd_front.sv
rtl/fvd_queue.sv
rtl/fvd_back.sv
rtl/feature_vector_distance_core.sv
tb/sv/feature_vector_distance_core_test.sv
